/* hdl/sld_pkg.sv */
// sld_pkg: shared constants, types and the kind decode for the sync/length deframer
// no dependencies; compile first
`timescale 1ns / 1ps

package sld_pkg;

    localparam int BYTE_W = 8;
    localparam int POS_W  = 17;
    localparam int KIND_W = 2;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [POS_W-1:0]  pos_t;
    typedef logic [KIND_W-1:0] kind_t;

    localparam byte_t SYNC_FIRST     = 8'h5A;
    localparam byte_t SYNC_SECOND    = 8'hA5;
    localparam byte_t CODE_HEARTBEAT = 8'hF1;
    localparam byte_t CODE_REGISTER  = 8'hF4;

    localparam pos_t HEADER_LEN = 17'd15;
    localparam pos_t KIND_POS   = 17'd10;
    localparam pos_t LEN_HI_POS = 17'd13;
    localparam pos_t LEN_LO_POS = 17'd14;

    localparam kind_t KIND_UNKNOWN   = 2'd0;
    localparam kind_t KIND_HEARTBEAT = 2'd1;
    localparam kind_t KIND_REGISTER  = 2'd2;
    localparam kind_t KIND_DATA      = 2'd3;

    function automatic kind_t decode_kind(input byte_t b);
        kind_t k;
        if (b == CODE_HEARTBEAT)
        begin
            k = KIND_HEARTBEAT;
        end
        else if (b == CODE_REGISTER)
        begin
            k = KIND_REGISTER;
        end
        else
        begin
            k = KIND_DATA;
        end
        return k;
    endfunction

endpackage

/* hdl/sld_if.sv */
// sld_in_if / sld_out_if: valid/ready channels for received bytes and frame bytes
// depends on sld_pkg
`timescale 1ns / 1ps

interface sld_in_if
    import sld_pkg::*;
();
    logic  valid;
    logic  ready;
    byte_t rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sld_out_if
    import sld_pkg::*;
();
    logic  valid;
    logic  ready;
    byte_t frame_byte;
    pos_t  byte_position;
    logic  frame_last;
    kind_t frame_kind;

    modport source (output valid, output frame_byte, output byte_position,
                    output frame_last, output frame_kind, input ready);
    modport sink   (input valid, input frame_byte, input byte_position,
                    input frame_last, input frame_kind, output ready);
endinterface

/* hdl/sync_length_frame_deframer_core.sv */
// sync_length_frame_deframer_core: sync hunt, length tracking and frame byte output
// depends on sld_pkg and the channel interfaces in sld_if.sv
`timescale 1ns / 1ps

// Takes one received byte per transaction on rx and gives frame bytes on frame.
// Bytes are dropped until the pair 0x5A 0xA5 is seen; from there the 15-byte
// header and the payload are passed on, the total length being the big-endian
// value in header bytes 13 and 14 plus 15. Each frame byte carries its position
// (0 at the first sync byte), a last mark and the frame kind decoded from byte 10
// (0 before byte 10). A 0x5A is only known to be a sync byte once the 0xA5 follows,
// so output runs one byte behind input: the final byte of a frame leaves when the
// next byte is received. Throughput is one byte per clock: each byte passes
// through one level of compare/increment logic into a single output register,
// and rx stays ready while that register is empty or being drained, so only
// backpressure on frame slows the block down. A byte released by a transaction
// appears on frame in the cycle after that transaction.
module sync_length_frame_deframer_core
    import sld_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    sld_in_if.sink           rx,
    sld_out_if.source        frame
);

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_SAW5A,
        PH_FRAME
    } phase_t;

    // hunt / frame state
    phase_t phase_reg, phase_next;
    pos_t   position_count_reg, position_count_next;   // position of the held byte
    byte_t  length_high_reg, length_high_next;
    pos_t   frame_total_reg, frame_total_next;
    kind_t  kind_code_reg, kind_code_next;
    byte_t  held_byte_reg, held_byte_next;
    logic   held_valid_reg, held_valid_next;

    // output register
    logic   out_valid_reg, out_valid_next;
    byte_t  out_byte_reg, out_byte_next;
    pos_t   out_pos_reg, out_pos_next;
    logic   out_last_reg, out_last_next;
    kind_t  out_kind_reg, out_kind_next;

    logic   accept;
    pos_t   q;          // position of the incoming byte inside a frame
    pos_t   total_new;  // frame total after this byte

    // accept while the output slot is free or being taken this cycle
    assign rx.ready = !out_valid_reg || frame.ready;
    assign accept   = rx.valid && rx.ready;

    assign q = position_count_reg + 17'd1;

    always_comb
    begin
        phase_next          = phase_reg;
        position_count_next = position_count_reg;
        length_high_next    = length_high_reg;
        frame_total_next    = frame_total_reg;
        kind_code_next      = kind_code_reg;
        held_byte_next      = held_byte_reg;
        held_valid_next     = held_valid_reg;
        out_byte_next       = out_byte_reg;
        out_pos_next        = out_pos_reg;
        out_last_next       = out_last_reg;
        out_kind_next       = out_kind_reg;
        out_valid_next      = out_valid_reg && !frame.ready;
        total_new           = frame_total_reg;

        if (accept)
        begin
            out_valid_next = 1'b0;

            // release the byte held from the previous transaction
            if (held_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_byte_next   = held_byte_reg;
                out_pos_next    = position_count_reg;
                out_last_next   = (position_count_reg >= LEN_LO_POS) &&
                                  ({1'b0, position_count_reg} + 18'd1 ==
                                   {1'b0, frame_total_reg});
                out_kind_next   = (position_count_reg >= KIND_POS) ? kind_code_reg
                                                                   : KIND_UNKNOWN;
                held_valid_next = 1'b0;
            end

            case (phase_reg)
                PH_FRAME:
                begin
                    if (q == KIND_POS)
                    begin
                        kind_code_next = decode_kind(rx.rx_byte);
                    end
                    if (q == LEN_HI_POS)
                    begin
                        length_high_next = rx.rx_byte;
                    end
                    if (q == LEN_LO_POS)
                    begin
                        total_new = {1'b0, length_high_reg, rx.rx_byte} + HEADER_LEN;
                    end
                    frame_total_next    = total_new;
                    held_byte_next      = rx.rx_byte;
                    held_valid_next     = 1'b1;
                    position_count_next = q;
                    // frame ends once this byte is the last one
                    if ((q >= LEN_LO_POS) && ({1'b0, q} + 18'd1 == {1'b0, total_new}))
                    begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_SAW5A:
                begin
                    if (rx.rx_byte == SYNC_SECOND)
                    begin
                        // sync confirmed: first sync byte leaves now, 0xA5 is held
                        out_valid_next      = 1'b1;
                        out_byte_next       = SYNC_FIRST;
                        out_pos_next        = '0;
                        out_last_next       = 1'b0;
                        out_kind_next       = KIND_UNKNOWN;
                        held_byte_next      = rx.rx_byte;
                        held_valid_next     = 1'b1;
                        position_count_next = 17'd1;
                        kind_code_next      = KIND_UNKNOWN;
                        length_high_next    = '0;
                        frame_total_next    = '0;
                        phase_next          = PH_FRAME;
                    end
                    else if (rx.rx_byte != SYNC_FIRST)
                    begin
                        phase_next = PH_HUNT;
                    end
                end
                default:
                begin
                    phase_next = (rx.rx_byte == SYNC_FIRST) ? PH_SAW5A : PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_HUNT;
            position_count_reg <= '0;
            length_high_reg    <= '0;
            frame_total_reg    <= '0;
            kind_code_reg      <= KIND_UNKNOWN;
            held_byte_reg      <= '0;
            held_valid_reg     <= 1'b0;
            out_valid_reg      <= 1'b0;
            out_byte_reg       <= '0;
            out_pos_reg        <= '0;
            out_last_reg       <= 1'b0;
            out_kind_reg       <= KIND_UNKNOWN;
        end
        else
        begin
            phase_reg          <= phase_next;
            position_count_reg <= position_count_next;
            length_high_reg    <= length_high_next;
            frame_total_reg    <= frame_total_next;
            kind_code_reg      <= kind_code_next;
            held_byte_reg      <= held_byte_next;
            held_valid_reg     <= held_valid_next;
            out_valid_reg      <= out_valid_next;
            out_byte_reg       <= out_byte_next;
            out_pos_reg        <= out_pos_next;
            out_last_reg       <= out_last_next;
            out_kind_reg       <= out_kind_next;
        end
    end

    assign frame.valid         = out_valid_reg;
    assign frame.frame_byte    = out_byte_reg;
    assign frame.byte_position = out_pos_reg;
    assign frame.frame_last    = out_last_reg;
    assign frame.frame_kind    = out_kind_reg;

    // inside a frame there is always a byte waiting to go out
    a_frame_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_FRAME) |-> held_valid_reg)
        else $error("frame phase without a held byte");

    // waiting for 0xa5 never coincides with a pending frame byte
    a_saw5a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_SAW5A) |-> !held_valid_reg)
        else $error("held byte pending while waiting for second sync byte");

    // a frame never ends inside the header
    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_last_reg) |-> (out_pos_reg >= LEN_LO_POS))
        else $error("last mark before end of header");

    // kind is only known from byte 10 on
    a_kind_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_kind_reg != KIND_UNKNOWN)) |-> (out_pos_reg >= KIND_POS))
        else $error("frame kind reported before byte 10");

    // a stalled result is never overwritten by a new transaction
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !frame.ready) |-> !accept)
        else $error("input accepted while output register is stalled");

endmodule
